// ===== hw/rtl/mpr_pkg.sv =====
package mpr_pkg;

  localparam int NUM_LEVELS  = 4;
  localparam int LEVEL_BITS  = 2;
  localparam int ENTITY_BITS = 8;

  typedef logic [1:0]            func_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [1:0]            status_t;

  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_PICK   = 2'd2;
  localparam func_t FUNC_NONE   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

endpackage

// ===== hw/rtl/multilevel_priority_round_robin_top.sv =====
// Four-level strict-priority run queue, round robin within each level.
// Command channel: present in_func, in_entity_id and in_level with start high;
// the item is taken at a clock edge where start is high and busy is low.
// busy stays high until the item is finished. Each item gives one result:
// out_valid is high for exactly one cycle with out_picked_valid,
// out_picked_id and out_status. The receiver cannot stall; the result is
// in an output register, and busy falls in the same cycle that out_valid
// rises, so a new item may be started while the result is shown.
// One item is in flight at a time.
// An unused code and a pick on an empty scheduler are answered from the idle
// state; add goes through S_ADD, pick through S_PICK_RD and S_PICK_WR, and
// remove through S_SCAN and S_SHIFT. Remove is bound by the ring memory's single
// read port: one entry is read per cycle to search the level, then one entry
// moved per cycle to close the gap. Each level is a ring with its own head
// pointer, so pick rotates the head in one write.
// Reset (rst_n low, synchronous) empties all levels and clears any item in
// progress; the entry memory itself needs no clearing.
module multilevel_priority_round_robin_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  mpr_pkg::func_t                     in_func,
  input  logic [mpr_pkg::ENTITY_BITS-1:0]    in_entity_id,
  input  mpr_pkg::level_t                    in_level,
  output logic                               out_valid,
  output logic                               out_picked_valid,
  output logic [mpr_pkg::ENTITY_BITS-1:0]    out_picked_id,
  output mpr_pkg::status_t                   out_status
);

  import mpr_pkg::*;

  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADD     = 3'd1;
  localparam logic [2:0] S_PICK_RD = 3'd2;
  localparam logic [2:0] S_PICK_WR = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r [NUM_LEVELS];
  logic [CW-1:0]      cnt_nxt [NUM_LEVELS];
  logic [PW-1:0]      head_r [NUM_LEVELS];
  logic [PW-1:0]      head_nxt [NUM_LEVELS];
  level_t             lvl_r, lvl_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CW-1:0]      off_r, off_nxt;
  logic [CW-1:0]      cmp_off_r, cmp_off_nxt;
  logic               have_r, have_nxt;
  logic [AW-1:0]      raddr_prev_r, raddr_prev_nxt;
  logic [AW-1:0]      waddr_r, waddr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_pv_r, out_pv_nxt;
  logic [ENTITY_BITS-1:0] out_id_r, out_id_nxt;
  status_t            out_st_r, out_st_nxt;

  logic [CW-1:0]      n;
  logic [PW-1:0]      head_cur;
  logic [CW-1:0]      addr_off;
  logic [AW-1:0]      unit_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [ID_BITS-1:0] rd_data;
  logic               match;
  logic               last_cmp;
  logic               pick_any;
  level_t             pick_lvl;
  logic               accept;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign n        = cnt_r[lvl_r];
  assign head_cur = head_r[lvl_r];
  assign addr_off = ((state_r == S_ADD) || (state_r == S_PICK_WR)) ? n : off_r;
  assign match    = (rd_data == id_r);
  assign last_cmp = (cmp_off_r == (n - CW'(1)));

  mpr_addr #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PW          (PW),
    .CW          (CW),
    .AW          (AW)
  ) u_addr (
    .level  (lvl_r),
    .head   (head_cur),
    .offset (addr_off),
    .addr   (unit_addr)
  );

  mpr_mem #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (ID_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (unit_addr),
    .rd_data (rd_data)
  );

  // Highest-priority nonempty level: lowest index wins.
  always_comb begin
    pick_any = 1'b0;
    pick_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        pick_any = 1'b1;
        pick_lvl = level_t'(l);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    lvl_nxt        = lvl_r;
    id_nxt         = id_r;
    off_nxt        = off_r;
    cmp_off_nxt    = cmp_off_r;
    have_nxt       = have_r;
    raddr_prev_nxt = raddr_prev_r;
    waddr_nxt      = waddr_r;
    out_valid_nxt  = 1'b0;
    out_pv_nxt     = 1'b0;
    out_id_nxt     = '0;
    out_st_nxt     = ST_OK;
    mem_we         = 1'b0;
    mem_waddr      = unit_addr;
    mem_wdata      = id_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lvl_nxt  = in_level;
          id_nxt   = ID_BITS'(in_entity_id);
          off_nxt  = '0;
          have_nxt = 1'b0;
          case (in_func)
            FUNC_ADD: begin
              state_nxt = S_ADD;
            end
            FUNC_REMOVE: begin
              state_nxt = S_SCAN;
            end
            FUNC_PICK: begin
              if (pick_any) begin
                lvl_nxt   = pick_lvl;
                state_nxt = S_PICK_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_st_nxt    = ST_EMPTY;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_st_nxt    = ST_OK;
            end
          endcase
        end
      end

      S_ADD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (n == FULL_CNT) begin
          out_st_nxt = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          cnt_nxt[lvl_r] = n + CW'(1);
        end
      end

      S_PICK_RD: begin
        state_nxt = S_PICK_WR;
      end

      S_PICK_WR: begin
        // Copy head to the tail slot, then advance the head.
        mem_we          = 1'b1;
        mem_wdata       = rd_data;
        head_nxt[lvl_r] = (head_cur == LAST_SLOT) ? '0 : (head_cur + PW'(1));
        out_valid_nxt   = 1'b1;
        out_pv_nxt      = 1'b1;
        out_id_nxt      = ENTITY_BITS'(rd_data);
        state_nxt       = S_IDLE;
      end

      S_SCAN: begin
        off_nxt        = off_r + CW'(1);
        cmp_off_nxt    = off_r;
        have_nxt       = (off_r < n);
        raddr_prev_nxt = unit_addr;
        if (have_r && match) begin
          if (last_cmp) begin
            cnt_nxt[lvl_r] = n - CW'(1);
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // The read in flight is the next slot: start moving entries forward.
            waddr_nxt = raddr_prev_r;
            state_nxt = S_SHIFT;
          end
        end else if ((n == '0) || (have_r && last_cmp)) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_NOT_FOUND;
          state_nxt     = S_IDLE;
        end
      end

      S_SHIFT: begin
        off_nxt        = off_r + CW'(1);
        cmp_off_nxt    = off_r;
        have_nxt       = (off_r < n);
        raddr_prev_nxt = unit_addr;
        mem_we         = 1'b1;
        mem_waddr      = waddr_r;
        mem_wdata      = rd_data;
        waddr_nxt      = raddr_prev_r;
        if (last_cmp) begin
          cnt_nxt[lvl_r] = n - CW'(1);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_r[l]  <= '0;
        head_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    id_r         <= id_nxt;
    off_r        <= off_nxt;
    cmp_off_r    <= cmp_off_nxt;
    raddr_prev_r <= raddr_prev_nxt;
    waddr_r      <= waddr_nxt;
    out_pv_r     <= out_pv_nxt;
    out_id_r     <= out_id_nxt;
    out_st_r     <= out_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_picked_valid = out_pv_r;
  assign out_picked_id    = out_id_r;
  assign out_status       = out_st_r;

  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("item finished without a result");

  a_unused_code: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_NONE)) |=>
      (out_valid && (out_status == ST_OK) && !out_picked_valid))
    else $error("unused code did not answer at once");

  a_pick_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_PICK) && !pick_any) |=>
      (out_valid && (out_status == ST_EMPTY) && !out_picked_valid))
    else $error("pick on empty scheduler not flagged");

  a_pick_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_picked_valid) |-> (out_status == ST_OK))
    else $error("picked id with error status");

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r[g] <= FULL_CNT))
      else $error("level count beyond queue depth");
  end

endmodule

// ===== hw/rtl/mpr_mem.sv =====
module mpr_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/mpr_addr.sv =====
module mpr_addr #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PW          = 4,
  parameter int CW          = 5,
  parameter int AW          = 6
) (
  input  mpr_pkg::level_t level,
  input  logic [PW-1:0]   head,
  input  logic [CW-1:0]   offset,
  output logic [AW-1:0]   addr
);

  logic [AW-1:0] sum;
  logic [AW-1:0] wrapped;
  logic [AW-1:0] base;

  // Slot position relative to the level's head, wrapped round the ring.
  always_comb begin
    sum     = AW'(head) + AW'(offset);
    wrapped = (sum >= AW'(QUEUE_DEPTH)) ? (sum - AW'(QUEUE_DEPTH)) : sum;
    base    = AW'(level) * AW'(QUEUE_DEPTH);
    addr    = base + wrapped;
  end

endmodule
